// ===== hw/rtl/sdsh_pkg.sv =====
// sdsh_pkg: types and constants for the sd card spi host sequencer
// no dependencies; used by sd_card_spi_host_sequencer

package sdsh_pkg;

   localparam int BLOCK_BYTES_DEF = 512;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_DATA_W = 17;

   // request kinds
   localparam logic [2:0] KIND_INIT  = 3'd0;
   localparam logic [2:0] KIND_READ  = 3'd1;
   localparam logic [2:0] KIND_WRITE = 3'd2;
   localparam logic [2:0] KIND_CARD  = 3'd3;
   localparam logic [2:0] KIND_WDATA = 3'd4;

   // config register indexes
   localparam logic [1:0] CSR_READY_WAIT = 2'd0;
   localparam logic [1:0] CSR_POLL       = 2'd1;
   localparam logic [1:0] CSR_TOKEN_WAIT = 2'd2;
   localparam logic [1:0] CSR_ACMD_RETRY = 2'd3;

   // chip select actions
   localparam logic [1:0] SEL_NONE    = 2'd0;
   localparam logic [1:0] SEL_ASSERT  = 2'd1;
   localparam logic [1:0] SEL_RELEASE = 2'd2;
   localparam logic [1:0] SEL_RESET   = 2'd3;

   // status codes
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_UNKNOWN    = 4'd1;
   localparam logic [3:0] ST_TIMEOUT    = 4'd2;
   localparam logic [3:0] ST_BAD_CARD   = 4'd3;
   localparam logic [3:0] ST_ACMD       = 4'd4;
   localparam logic [3:0] ST_OCR        = 4'd5;
   localparam logic [3:0] ST_BLOCK      = 4'd6;
   localparam logic [3:0] ST_UNSUPP     = 4'd7;
   localparam logic [3:0] ST_WR_RESP    = 4'd8;
   localparam logic [3:0] ST_WR_STAT1   = 4'd9;
   localparam logic [3:0] ST_WR_STAT2   = 4'd10;
   localparam logic [3:0] ST_WR_TIMEOUT = 4'd11;

   // card commands
   localparam logic [5:0] CMD0  = 6'd0;
   localparam logic [5:0] CMD8  = 6'd8;
   localparam logic [5:0] CMD13 = 6'd13;
   localparam logic [5:0] CMD17 = 6'd17;
   localparam logic [5:0] CMD24 = 6'd24;
   localparam logic [5:0] CMD41 = 6'd41;
   localparam logic [5:0] CMD55 = 6'd55;
   localparam logic [5:0] CMD58 = 6'd58;

   localparam logic [7:0] CRC_CMD0  = 8'h95;
   localparam logic [7:0] CRC_CMD8  = 8'h87;
   localparam logic [7:0] CRC_OTHER = 8'hFF;
   localparam logic [31:0] ARG_CMD8 = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS  = 32'h4000_0000;
   localparam logic [7:0] IDLE_BYTE  = 8'hFF;
   localparam logic [7:0] DATA_TOKEN = 8'hFE;
   localparam logic [7:0] CHECK_BYTE = 8'hAA;
   localparam logic [7:0] CMD_START  = 8'h40;
   localparam logic [4:0] DRESP_OK   = 5'h05;

   typedef enum logic [1:0] {
      OP_NONE, OP_INIT, OP_READ, OP_WRITE
   } op_type;

   typedef enum logic [1:0] {
      CARD_UNKNOWN, CARD_SD1, CARD_SD2, CARD_SDHC
   } card_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_RDY, PH_CMDB, PH_POLL, PH_R7, PH_OCR, PH_TOKEN, PH_RDATA,
      PH_WTOK, PH_WNEED, PH_WDATA, PH_WCRC, PH_WBUSY, PH_STAT2
   } phase_type;

   typedef struct packed {
      logic [1:0] select_action;
      logic       send_valid;
      logic [7:0] send_byte;
      logic       want_write_byte;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_last;
      logic       done_res;
      logic [3:0] status_code;
      logic [1:0] card_type;
      logic [7:0] card_error_byte;
   } rsp_type;

endpackage

// ===== hw/rtl/sd_card_spi_host_sequencer.sv =====
// sd_card_spi_host_sequencer: sd card spi-mode init, block read and block write sequencer
// depends on sdsh_pkg
// each transaction is handled in the cycle it is accepted and its 0 to 3 results are
// registered; while rsp_tready is high results leave one per cycle, the first in the
// cycle after acceptance, and transactions are taken one per cycle while each causes
// at most one result, else the next waits for the last. synchronous reset to idle, card unknown.

module sd_card_spi_host_sequencer #(
   parameter int BLOCK_BYTES = sdsh_pkg::BLOCK_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // block_address, card_byte, write_byte, timeout_flag, zero pad
   input  logic [sdsh_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // select_action, send_valid, send_byte, want_write_byte, read_valid, read_byte,
   // done_res, status_code, card_type, card_error_byte, zero pad
   output logic [sdsh_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_write,
   input  logic [1:0]                      csr_index,
   input  logic [sdsh_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int BI_CW = $clog2(BLOCK_BYTES + 1);
   localparam int BI_W  = (BI_CW > 3) ? BI_CW : 3;
   localparam logic [BI_W-1:0] BLK_LAST = BI_W'(BLOCK_BYTES);

   logic [16:0] ready_lim_ff;
   logic [8:0]  poll_lim_ff;
   logic [15:0] token_lim_ff;
   logic [15:0] acmd_lim_ff;

   sdsh_pkg::phase_type phase_ff, phase_in;
   sdsh_pkg::op_type    pend_ff, pend_in;
   sdsh_pkg::card_type  ckind_ff, ckind_in;
   logic [16:0]     wc_ff, wc_in;
   logic [15:0]     rc_ff, rc_in;
   logic [BI_W-1:0] bi_ff, bi_in;
   logic [5:0]      cc_ff, cc_in;
   logic [31:0]     carg_ff, carg_in;
   logic [31:0]     tb_ff, tb_in;
   logic [3:0]      ls_ff, ls_in;
   logic [7:0]      lce_ff, lce_in;

   sdsh_pkg::rsp_type slot_ff [4];
   sdsh_pkg::rsp_type slot_in [4];
   logic [2:0] rem_ff, rem_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] n_res;

   logic        accept;
   logic [2:0]  kind;
   logic [31:0] addr;
   logic [7:0]  cbyte;
   logic [7:0]  wbyte;
   logic        tflag;
   logic [16:0] ready_lim1;
   logic [8:0]  poll_lim1;
   logic [15:0] token_lim1;

   assign kind  = req_tuser;
   assign addr  = req_tdata[31:0];
   assign cbyte = req_tdata[39:32];
   assign wbyte = req_tdata[47:40];
   assign tflag = req_tdata[48];

   assign ready_lim1 = (ready_lim_ff == '0) ? 17'd1 : ready_lim_ff;
   assign poll_lim1  = (poll_lim_ff == '0) ? 9'd1 : poll_lim_ff;
   assign token_lim1 = (token_lim_ff == '0) ? 16'd1 : token_lim_ff;

   assign req_tready = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_tready);
   assign accept     = req_tvalid && req_tready;

   function automatic sdsh_pkg::rsp_type mk(input logic [1:0] sel, input logic sv,
         input logic [7:0] sb, input logic want, input logic rv, input logic [7:0] rb,
         input logic rl, input logic dn, input logic [3:0] st, input logic [1:0] ck,
         input logic [7:0] ce);
      sdsh_pkg::rsp_type r;
      r.select_action   = sel;
      r.send_valid      = sv;
      r.send_byte       = sb;
      r.want_write_byte = want;
      r.read_valid      = rv;
      r.read_byte       = rb;
      r.read_last       = rl;
      r.done_res        = dn;
      r.status_code     = st;
      r.card_type       = ck;
      r.card_error_byte = ce;
      return r;
   endfunction

   always_comb begin
      logic        fin_en;
      logic [3:0]  fin_st;
      logic        ie_en;
      logic [3:0]  ie_st;
      logic        rwp_en;
      logic        sc_en;
      logic [5:0]  sc_code;
      logic [31:0] sc_arg;
      logic        resp_en;
      logic        xv;
      logic [7:0]  xb;

      phase_in = phase_ff;
      pend_in  = pend_ff;
      ckind_in = ckind_ff;
      wc_in    = wc_ff;
      rc_in    = rc_ff;
      bi_in    = bi_ff;
      cc_in    = cc_ff;
      carg_in  = carg_ff;
      tb_in    = tb_ff;
      ls_in    = ls_ff;
      lce_in   = lce_ff;
      for (int i = 0; i < 4; i++) begin
         slot_in[i] = slot_ff[i];
      end
      n_res   = 3'd0;
      fin_en  = 1'b0;
      fin_st  = sdsh_pkg::ST_OK;
      ie_en   = 1'b0;
      ie_st   = sdsh_pkg::ST_OK;
      rwp_en  = 1'b0;
      sc_en   = 1'b0;
      sc_code = sdsh_pkg::CMD0;
      sc_arg  = '0;
      resp_en = 1'b0;
      xv      = 1'b0;
      xb      = sdsh_pkg::IDLE_BYTE;

      if ((kind == sdsh_pkg::KIND_INIT || kind == sdsh_pkg::KIND_READ
            || kind == sdsh_pkg::KIND_WRITE) && phase_ff == sdsh_pkg::PH_IDLE) begin
         ls_in = sdsh_pkg::ST_OK;
         if (kind == sdsh_pkg::KIND_INIT) begin
            pend_in = sdsh_pkg::OP_INIT;
            rc_in = '0;
            slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_RESET, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0,
               1'b0, 1'b0, ls_in, ckind_in, lce_in);
            n_res = n_res + 3'd1;
            sc_en = 1'b1; sc_code = sdsh_pkg::CMD0; sc_arg = '0;
         end else begin
            pend_in = (kind == sdsh_pkg::KIND_READ) ? sdsh_pkg::OP_READ : sdsh_pkg::OP_WRITE;
            tb_in = addr;
            if (kind == sdsh_pkg::KIND_WRITE) lce_in = '0;
            slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_RELEASE, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0,
               1'b0, 1'b0, ls_in, ckind_in, lce_in);
            n_res = n_res + 3'd1;
            if (tflag) begin
               rc_in = '0;
               slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_RESET, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0,
                  1'b0, 1'b0, ls_in, ckind_in, lce_in);
               n_res = n_res + 3'd1;
               sc_en = 1'b1; sc_code = sdsh_pkg::CMD0; sc_arg = '0;
            end else begin
               rwp_en = 1'b1;
            end
         end
      end else if (kind == sdsh_pkg::KIND_CARD && phase_ff != sdsh_pkg::PH_IDLE
            && phase_ff != sdsh_pkg::PH_WNEED) begin
         case (phase_ff)
            sdsh_pkg::PH_RDY: begin
               if (cbyte == sdsh_pkg::IDLE_BYTE) begin
                  phase_in = sdsh_pkg::PH_CMDB;
                  bi_in = '0;
                  xv = 1'b1; xb = sdsh_pkg::CMD_START | {2'b00, cc_ff};
               end else begin
                  wc_in = wc_ff + 17'd1;
                  if (wc_in >= ready_lim1) begin
                     if (cc_ff == sdsh_pkg::CMD0 || cc_ff == sdsh_pkg::CMD8
                           || cc_ff == sdsh_pkg::CMD55 || cc_ff == sdsh_pkg::CMD41
                           || cc_ff == sdsh_pkg::CMD58) begin
                        ie_en = 1'b1; ie_st = sdsh_pkg::ST_TIMEOUT;
                     end else begin
                        fin_en = 1'b1; fin_st = sdsh_pkg::ST_TIMEOUT;
                     end
                  end else begin
                     xv = 1'b1;
                  end
               end
            end
            sdsh_pkg::PH_CMDB: begin
               bi_in = bi_ff + 1'b1;
               xv = 1'b1;
               case (bi_in[2:0])
                  3'd1: xb = carg_ff[31:24];
                  3'd2: xb = carg_ff[23:16];
                  3'd3: xb = carg_ff[15:8];
                  3'd4: xb = carg_ff[7:0];
                  3'd5: xb = (cc_ff == sdsh_pkg::CMD0) ? sdsh_pkg::CRC_CMD0 :
                        ((cc_ff == sdsh_pkg::CMD8) ? sdsh_pkg::CRC_CMD8 : sdsh_pkg::CRC_OTHER);
                  default: begin
                     phase_in = sdsh_pkg::PH_POLL;
                     wc_in = '0;
                     xb = sdsh_pkg::IDLE_BYTE;
                  end
               endcase
            end
            sdsh_pkg::PH_POLL: begin
               wc_in = wc_ff + 17'd1;
               if (!cbyte[7] || wc_in >= {8'd0, poll_lim1}) resp_en = 1'b1;
               else xv = 1'b1;
            end
            sdsh_pkg::PH_R7: begin
               bi_in = bi_ff + 1'b1;
               if (bi_in < BI_W'(4)) xv = 1'b1;
               else if (cbyte != sdsh_pkg::CHECK_BYTE) begin
                  ie_en = 1'b1; ie_st = sdsh_pkg::ST_BAD_CARD;
               end else begin
                  ckind_in = sdsh_pkg::CARD_SD2;
                  sc_en = 1'b1; sc_code = sdsh_pkg::CMD55; sc_arg = '0;
               end
            end
            sdsh_pkg::PH_OCR: begin
               if (bi_ff == '0 && cbyte[7:6] == 2'b11) ckind_in = sdsh_pkg::CARD_SDHC;
               bi_in = bi_ff + 1'b1;
               if (bi_in < BI_W'(4)) xv = 1'b1;
               else begin
                  ie_en = 1'b1; ie_st = sdsh_pkg::ST_OK;
               end
            end
            sdsh_pkg::PH_TOKEN: begin
               if (cbyte == sdsh_pkg::IDLE_BYTE) begin
                  wc_in = wc_ff + 17'd1;
                  if (wc_in >= {1'b0, token_lim1}) begin
                     fin_en = 1'b1; fin_st = sdsh_pkg::ST_TIMEOUT;
                  end else xv = 1'b1;
               end else if (cbyte != sdsh_pkg::DATA_TOKEN) begin
                  fin_en = 1'b1; fin_st = sdsh_pkg::ST_BLOCK;
               end else begin
                  phase_in = sdsh_pkg::PH_RDATA;
                  bi_in = '0;
                  xv = 1'b1;
               end
            end
            sdsh_pkg::PH_RDATA: begin
               bi_in = bi_ff + 1'b1;
               if (bi_in >= BLK_LAST) begin
                  slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_NONE, 1'b0, 8'd0, 1'b0, 1'b1, cbyte,
                     1'b1, 1'b0, ls_in, ckind_in, lce_in);
                  n_res = n_res + 3'd1;
                  fin_en = 1'b1; fin_st = sdsh_pkg::ST_OK;
               end else begin
                  slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_NONE, 1'b0, 8'd0, 1'b0, 1'b1, cbyte,
                     1'b0, 1'b0, ls_in, ckind_in, lce_in);
                  n_res = n_res + 3'd1;
                  xv = 1'b1;
               end
            end
            sdsh_pkg::PH_WTOK: begin
               phase_in = sdsh_pkg::PH_WNEED;
               bi_in = '0;
               slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_NONE, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0,
                  1'b0, 1'b0, ls_in, ckind_in, lce_in);
               n_res = n_res + 3'd1;
            end
            sdsh_pkg::PH_WDATA: begin
               bi_in = bi_ff + 1'b1;
               if (bi_in < BLK_LAST) begin
                  phase_in = sdsh_pkg::PH_WNEED;
                  slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_NONE, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0,
                     1'b0, 1'b0, ls_in, ckind_in, lce_in);
                  n_res = n_res + 3'd1;
               end else begin
                  phase_in = sdsh_pkg::PH_WCRC;
                  bi_in = '0;
                  xv = 1'b1;
               end
            end
            sdsh_pkg::PH_WCRC: begin
               bi_in = bi_ff + 1'b1;
               if (bi_in < BI_W'(3)) xv = 1'b1;
               else if (cbyte[4:0] != sdsh_pkg::DRESP_OK) begin
                  fin_en = 1'b1; fin_st = sdsh_pkg::ST_WR_RESP;
               end else begin
                  phase_in = sdsh_pkg::PH_WBUSY;
                  wc_in = '0;
                  xv = 1'b1;
               end
            end
            sdsh_pkg::PH_WBUSY: begin
               if (cbyte == sdsh_pkg::IDLE_BYTE) begin
                  wc_in = wc_ff + 17'd1;
                  if (wc_in >= {1'b0, token_lim1}) begin
                     fin_en = 1'b1; fin_st = sdsh_pkg::ST_WR_TIMEOUT;
                  end else xv = 1'b1;
               end else begin
                  sc_en = 1'b1; sc_code = sdsh_pkg::CMD13; sc_arg = '0;
               end
            end
            sdsh_pkg::PH_STAT2: begin
               fin_en = 1'b1;
               if (cbyte != 8'd0) begin
                  lce_in = cbyte;
                  fin_st = sdsh_pkg::ST_WR_STAT2;
               end else fin_st = sdsh_pkg::ST_OK;
            end
            default: ;
         endcase
      end else if (kind == sdsh_pkg::KIND_WDATA && phase_ff == sdsh_pkg::PH_WNEED) begin
         phase_in = sdsh_pkg::PH_WDATA;
         xv = 1'b1; xb = wbyte;
      end

      // r1 response dispatch
      if (resp_en) begin
         case (cc_ff)
            sdsh_pkg::CMD0: begin
               if (cbyte != 8'd1) begin
                  ie_en = 1'b1; ie_st = sdsh_pkg::ST_UNKNOWN;
               end else begin
                  sc_en = 1'b1; sc_code = sdsh_pkg::CMD8; sc_arg = sdsh_pkg::ARG_CMD8;
               end
            end
            sdsh_pkg::CMD8: begin
               if (cbyte[2]) begin
                  ckind_in = sdsh_pkg::CARD_SD1;
                  sc_en = 1'b1; sc_code = sdsh_pkg::CMD55; sc_arg = '0;
               end else begin
                  phase_in = sdsh_pkg::PH_R7; bi_in = '0; xv = 1'b1;
               end
            end
            sdsh_pkg::CMD55: begin
               sc_en = 1'b1; sc_code = sdsh_pkg::CMD41;
               sc_arg = (ckind_in == sdsh_pkg::CARD_SD2) ? sdsh_pkg::ARG_HCS : '0;
            end
            sdsh_pkg::CMD41: begin
               if (cbyte == 8'd0) begin
                  if (ckind_in == sdsh_pkg::CARD_SD2) begin
                     sc_en = 1'b1; sc_code = sdsh_pkg::CMD58; sc_arg = '0;
                  end else begin
                     ie_en = 1'b1; ie_st = sdsh_pkg::ST_OK;
                  end
               end else if (rc_ff >= acmd_lim_ff) begin
                  ie_en = 1'b1; ie_st = sdsh_pkg::ST_ACMD;
               end else begin
                  rc_in = rc_ff + 16'd1;
                  sc_en = 1'b1; sc_code = sdsh_pkg::CMD55; sc_arg = '0;
               end
            end
            sdsh_pkg::CMD58: begin
               if (cbyte != 8'd0) begin
                  ie_en = 1'b1; ie_st = sdsh_pkg::ST_OCR;
               end else begin
                  phase_in = sdsh_pkg::PH_OCR; bi_in = '0; xv = 1'b1;
               end
            end
            sdsh_pkg::CMD17: begin
               if (cbyte != 8'd0) begin
                  fin_en = 1'b1; fin_st = sdsh_pkg::ST_BLOCK;
               end else begin
                  phase_in = sdsh_pkg::PH_TOKEN; wc_in = '0; xv = 1'b1;
               end
            end
            sdsh_pkg::CMD24: begin
               if (cbyte != 8'd0) begin
                  fin_en = 1'b1; fin_st = sdsh_pkg::ST_BLOCK;
               end else begin
                  phase_in = sdsh_pkg::PH_WTOK; xv = 1'b1; xb = sdsh_pkg::DATA_TOKEN;
               end
            end
            sdsh_pkg::CMD13: begin
               if (cbyte != 8'd0) begin
                  lce_in = cbyte;
                  fin_en = 1'b1; fin_st = sdsh_pkg::ST_WR_STAT1;
               end else begin
                  phase_in = sdsh_pkg::PH_STAT2; xv = 1'b1;
               end
            end
            default: begin
               fin_en = 1'b1; fin_st = sdsh_pkg::ST_UNKNOWN;
            end
         endcase
      end

      if (xv) begin
         slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_NONE, 1'b1, xb, 1'b0, 1'b0, 8'd0,
            1'b0, 1'b0, ls_in, ckind_in, lce_in);
         n_res = n_res + 3'd1;
      end

      // end of initialization
      if (ie_en) begin
         if (pend_ff == sdsh_pkg::OP_INIT) begin
            fin_en = 1'b1; fin_st = ie_st;
         end else begin
            ls_in = ie_st;
            slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_RELEASE, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0,
               1'b0, 1'b0, ls_in, ckind_in, lce_in);
            n_res = n_res + 3'd1;
            rwp_en = 1'b1;
         end
      end

      // sdhc check before read or write
      if (rwp_en) begin
         if (ckind_in != sdsh_pkg::CARD_SDHC) begin
            fin_en = 1'b1; fin_st = sdsh_pkg::ST_UNSUPP;
         end else begin
            sc_en = 1'b1;
            sc_code = (pend_in == sdsh_pkg::OP_READ) ? sdsh_pkg::CMD17 : sdsh_pkg::CMD24;
            sc_arg = tb_in;
         end
      end

      if (fin_en) begin
         ls_in = fin_st;
         phase_in = sdsh_pkg::PH_IDLE;
         pend_in = sdsh_pkg::OP_NONE;
         slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_RELEASE, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0,
            1'b0, 1'b1, ls_in, ckind_in, lce_in);
         n_res = n_res + 3'd1;
      end

      if (sc_en) begin
         cc_in = sc_code;
         carg_in = sc_arg;
         phase_in = sdsh_pkg::PH_RDY;
         wc_in = '0;
         slot_in[n_res[1:0]] = mk(sdsh_pkg::SEL_ASSERT, 1'b1, sdsh_pkg::IDLE_BYTE, 1'b0,
            1'b0, 8'd0, 1'b0, 1'b0, ls_in, ckind_in, lce_in);
         n_res = n_res + 3'd1;
      end
   end

   always_comb begin
      rem_in = rem_ff;
      rd_in  = rd_ff;
      if (accept) begin
         rem_in = n_res;
         rd_in  = '0;
      end else if (rsp_tvalid && rsp_tready) begin
         rem_in = rem_ff - 3'd1;
         rd_in  = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_lim_ff <= 17'd65536;
         poll_lim_ff  <= 9'd256;
         token_lim_ff <= 16'd8192;
         acmd_lim_ff  <= 16'd8192;
      end else if (csr_write) begin
         case (csr_index)
            sdsh_pkg::CSR_READY_WAIT: ready_lim_ff <= csr_data;
            sdsh_pkg::CSR_POLL:       poll_lim_ff  <= csr_data[8:0];
            sdsh_pkg::CSR_TOKEN_WAIT: token_lim_ff <= csr_data[15:0];
            sdsh_pkg::CSR_ACMD_RETRY: acmd_lim_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdsh_pkg::PH_IDLE;
         pend_ff  <= sdsh_pkg::OP_NONE;
         ckind_ff <= sdsh_pkg::CARD_UNKNOWN;
         wc_ff    <= '0;
         rc_ff    <= '0;
         bi_ff    <= '0;
         cc_ff    <= '0;
         carg_ff  <= '0;
         tb_ff    <= '0;
         ls_ff    <= '0;
         lce_ff   <= '0;
         rem_ff   <= '0;
         rd_ff    <= '0;
      end else begin
         rem_ff <= rem_in;
         rd_ff  <= rd_in;
         if (accept) begin
            phase_ff <= phase_in;
            pend_ff  <= pend_in;
            ckind_ff <= ckind_in;
            wc_ff    <= wc_in;
            rc_ff    <= rc_in;
            bi_ff    <= bi_in;
            cc_ff    <= cc_in;
            carg_ff  <= carg_in;
            tb_ff    <= tb_in;
            ls_ff    <= ls_in;
            lce_ff   <= lce_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 4; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   sdsh_pkg::rsp_type cur;
   assign cur        = slot_ff[rd_ff];
   assign rsp_tvalid = (rem_ff != 3'd0);
   assign rsp_tlast  = cur.read_last;
   assign rsp_tdata  = {4'd0, cur.card_error_byte, cur.card_type, cur.status_code,
      cur.done_res, cur.read_byte, cur.read_valid, cur.want_write_byte, cur.send_byte,
      cur.send_valid, cur.select_action};

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for sd_card_spi_host_sequencer
// acts as the card and the host, predicts every result in sv and checks it
// depends on sdsh_pkg and the sd_card_spi_host_sequencer rtl

module tb_top;
   import sdsh_pkg::*;

   localparam int BLOCK = 8;

   typedef struct {
      logic [1:0] sel;
      logic       send_v;
      logic [7:0] send_b;
      logic       want;
      logic       rd_v;
      logic [7:0] rd_b;
      logic       rd_last;
      logic       done;
      logic [3:0] status;
      logic [1:0] ctype;
      logic [7:0] cerr;
   } spi_result_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_write = 0;
   logic [1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   sd_card_spi_host_sequencer #(.BLOCK_BYTES(BLOCK)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("sd_card_spi_host_sequencer regression: fail");
      $finish;
   end

   // predicted card sequencer state
   int unsigned lim_ready, lim_poll, lim_token, lim_acmd;
   phase_type   pr_phase;
   op_type      pr_op;
   card_type    pr_card;
   int unsigned pr_wait, pr_retry, pr_index;
   logic [5:0]  pr_cmd;
   logic [31:0] pr_arg, pr_block;
   logic [3:0]  pr_status;
   logic [7:0]  pr_card_err, pr_resp;
   int          item_results;

   spi_result_t expected_q[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int items_sent = 0;

   function automatic int unsigned at_least_one(int unsigned v);
      return v == 0 ? 1 : v;
   endfunction

   function automatic void push_result(logic [1:0] sel, logic sv, logic [7:0] sb, logic want,
                                       logic rv, logic [7:0] rb, logic rl, logic done);
      spi_result_t r;
      if (item_results >= 4) return;
      r.sel = sel; r.send_v = sv; r.send_b = sb; r.want = want;
      r.rd_v = rv; r.rd_b = rb; r.rd_last = rl; r.done = done;
      r.status = pr_status; r.ctype = pr_card; r.cerr = pr_card_err;
      expected_q.push_back(r);
      item_results++;
   endfunction

   function automatic void exchange(logic [7:0] b);
      push_result(SEL_NONE, 1, b, 0, 0, 0, 0, 0);
   endfunction

   function automatic void finish_op(logic [3:0] st);
      pr_status = st;
      pr_phase = PH_IDLE;
      pr_op = OP_NONE;
      push_result(SEL_RELEASE, 0, 0, 0, 0, 0, 0, 1);
   endfunction

   function automatic void start_command(logic [5:0] code, logic [31:0] arg);
      pr_cmd = code;
      pr_arg = arg;
      pr_phase = PH_RDY;
      pr_wait = 0;
      push_result(SEL_ASSERT, 1, IDLE_BYTE, 0, 0, 0, 0, 0);
   endfunction

   function automatic void transfer_proceed();
      if (pr_card != CARD_SDHC) begin
         finish_op(ST_UNSUPP);
         return;
      end
      start_command(pr_op == OP_READ ? CMD17 : CMD24, pr_block);
   endfunction

   function automatic void init_done(logic [3:0] st);
      if (pr_op == OP_INIT) begin
         finish_op(st);
         return;
      end
      pr_status = st;
      push_result(SEL_RELEASE, 0, 0, 0, 0, 0, 0, 0);
      transfer_proceed();
   endfunction

   function automatic void start_init();
      pr_retry = 0;
      push_result(SEL_RESET, 0, 0, 0, 0, 0, 0, 0);
      start_command(CMD0, 0);
   endfunction

   function automatic void r1_received(logic [7:0] r);
      case (pr_cmd)
         CMD0: if (r != 8'h01) init_done(ST_UNKNOWN); else start_command(CMD8, ARG_CMD8);
         CMD8: begin
            if (r[2]) begin
               pr_card = CARD_SD1;
               start_command(CMD55, 0);
            end else begin
               pr_phase = PH_R7; pr_index = 0; exchange(IDLE_BYTE);
            end
         end
         CMD55: start_command(CMD41, pr_card == CARD_SD2 ? ARG_HCS : 32'h0);
         CMD41: begin
            if (r == 0) begin
               if (pr_card == CARD_SD2) start_command(CMD58, 0); else init_done(ST_OK);
            end else if (pr_retry >= lim_acmd) begin
               init_done(ST_ACMD);
            end else begin
               pr_retry++;
               start_command(CMD55, 0);
            end
         end
         CMD58: begin
            if (r != 0) init_done(ST_OCR);
            else begin pr_phase = PH_OCR; pr_index = 0; exchange(IDLE_BYTE); end
         end
         CMD17: begin
            if (r != 0) finish_op(ST_BLOCK);
            else begin pr_phase = PH_TOKEN; pr_wait = 0; exchange(IDLE_BYTE); end
         end
         CMD24: begin
            if (r != 0) finish_op(ST_BLOCK);
            else begin pr_phase = PH_WTOK; exchange(DATA_TOKEN); end
         end
         CMD13: begin
            if (r != 0) begin pr_card_err = r; finish_op(ST_WR_STAT1); end
            else begin pr_phase = PH_STAT2; exchange(IDLE_BYTE); end
         end
         default: finish_op(ST_UNKNOWN);
      endcase
   endfunction

   function automatic void card_byte_in(logic [7:0] b);
      logic init_cmd;
      case (pr_phase)
         PH_RDY: begin
            if (b == IDLE_BYTE) begin
               pr_phase = PH_CMDB; pr_index = 0;
               exchange(CMD_START | {2'b00, pr_cmd});
            end else begin
               pr_wait++;
               if (pr_wait >= at_least_one(lim_ready)) begin
                  init_cmd = pr_cmd == CMD0 || pr_cmd == CMD8 || pr_cmd == CMD55 ||
                             pr_cmd == CMD41 || pr_cmd == CMD58;
                  if (init_cmd) init_done(ST_TIMEOUT); else finish_op(ST_TIMEOUT);
               end else exchange(IDLE_BYTE);
            end
         end
         PH_CMDB: begin
            pr_index++;
            if (pr_index < 5) exchange(pr_arg >> (8 * (4 - pr_index)));
            else if (pr_index == 5)
               exchange(pr_cmd == CMD0 ? CRC_CMD0 : (pr_cmd == CMD8 ? CRC_CMD8 : CRC_OTHER));
            else begin pr_phase = PH_POLL; pr_wait = 0; exchange(IDLE_BYTE); end
         end
         PH_POLL: begin
            pr_resp = b;
            pr_wait++;
            if (!b[7] || pr_wait >= at_least_one(lim_poll)) r1_received(b);
            else exchange(IDLE_BYTE);
         end
         PH_R7: begin
            pr_index++;
            if (pr_index < 4) exchange(IDLE_BYTE);
            else if (b != CHECK_BYTE) init_done(ST_BAD_CARD);
            else begin pr_card = CARD_SD2; start_command(CMD55, 0); end
         end
         PH_OCR: begin
            if (pr_index == 0 && b[7:6] == 2'b11) pr_card = CARD_SDHC;
            pr_index++;
            if (pr_index < 4) exchange(IDLE_BYTE); else init_done(ST_OK);
         end
         PH_TOKEN: begin
            if (b == IDLE_BYTE) begin
               pr_wait++;
               if (pr_wait >= at_least_one(lim_token)) finish_op(ST_TIMEOUT);
               else exchange(IDLE_BYTE);
            end else if (b != DATA_TOKEN) finish_op(ST_BLOCK);
            else begin pr_phase = PH_RDATA; pr_index = 0; exchange(IDLE_BYTE); end
         end
         PH_RDATA: begin
            pr_index++;
            if (pr_index >= BLOCK) begin
               push_result(SEL_NONE, 0, 0, 0, 1, b, 1, 0);
               finish_op(ST_OK);
            end else begin
               push_result(SEL_NONE, 0, 0, 0, 1, b, 0, 0);
               exchange(IDLE_BYTE);
            end
         end
         PH_WTOK: begin
            pr_phase = PH_WNEED; pr_index = 0;
            push_result(SEL_NONE, 0, 0, 1, 0, 0, 0, 0);
         end
         PH_WDATA: begin
            pr_index++;
            if (pr_index < BLOCK) begin
               pr_phase = PH_WNEED;
               push_result(SEL_NONE, 0, 0, 1, 0, 0, 0, 0);
            end else begin pr_phase = PH_WCRC; pr_index = 0; exchange(IDLE_BYTE); end
         end
         PH_WCRC: begin
            pr_index++;
            if (pr_index < 3) exchange(IDLE_BYTE);
            else if (b[4:0] != DRESP_OK) finish_op(ST_WR_RESP);
            else begin pr_phase = PH_WBUSY; pr_wait = 0; exchange(IDLE_BYTE); end
         end
         PH_WBUSY: begin
            if (b == IDLE_BYTE) begin
               pr_wait++;
               if (pr_wait >= at_least_one(lim_token)) finish_op(ST_WR_TIMEOUT);
               else exchange(IDLE_BYTE);
            end else start_command(CMD13, 0);
         end
         PH_STAT2: begin
            if (b != 0) begin pr_card_err = b; finish_op(ST_WR_STAT2); end
            else finish_op(ST_OK);
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_transaction(logic [2:0] kind, logic [31:0] addr,
                                               logic [7:0] cb, logic [7:0] wb, logic to);
      item_results = 0;
      if (kind == KIND_INIT || kind == KIND_READ || kind == KIND_WRITE) begin
         if (pr_phase != PH_IDLE) return;
         pr_status = ST_OK;
         if (kind == KIND_INIT) begin
            pr_op = OP_INIT;
            start_init();
            return;
         end
         pr_op = kind == KIND_READ ? OP_READ : OP_WRITE;
         pr_block = addr;
         if (kind == KIND_WRITE) pr_card_err = 0;
         push_result(SEL_RELEASE, 0, 0, 0, 0, 0, 0, 0);
         if (to) start_init(); else transfer_proceed();
      end else if (kind == KIND_CARD) begin
         if (pr_phase != PH_IDLE && pr_phase != PH_WNEED) card_byte_in(cb);
      end else if (kind == KIND_WDATA) begin
         if (pr_phase == PH_WNEED) begin
            pr_phase = PH_WDATA;
            exchange(wb);
         end
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_result();
      spi_result_t e;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         return;
      end
      e = expected_q.pop_front();
      if (rsp_tdata[1:0] !== e.sel)
         report_mismatch($sformatf("select_action %0d, want %0d", rsp_tdata[1:0], e.sel));
      if (rsp_tdata[2] !== e.send_v)
         report_mismatch($sformatf("send_valid %0d, want %0d", rsp_tdata[2], e.send_v));
      if (rsp_tdata[10:3] !== e.send_b)
         report_mismatch($sformatf("send_byte %h, want %h", rsp_tdata[10:3], e.send_b));
      if (rsp_tdata[11] !== e.want)
         report_mismatch($sformatf("want_write_byte %0d, want %0d", rsp_tdata[11], e.want));
      if (rsp_tdata[12] !== e.rd_v)
         report_mismatch($sformatf("read_valid %0d, want %0d", rsp_tdata[12], e.rd_v));
      if (rsp_tdata[20:13] !== e.rd_b)
         report_mismatch($sformatf("read_byte %h, want %h", rsp_tdata[20:13], e.rd_b));
      if (rsp_tlast !== e.rd_last)
         report_mismatch($sformatf("read_last %0d, want %0d", rsp_tlast, e.rd_last));
      if (rsp_tdata[21] !== e.done)
         report_mismatch($sformatf("done_res %0d, want %0d", rsp_tdata[21], e.done));
      if (rsp_tdata[25:22] !== e.status)
         report_mismatch($sformatf("status_code %0d, want %0d", rsp_tdata[25:22], e.status));
      if (rsp_tdata[27:26] !== e.ctype)
         report_mismatch($sformatf("card_type %0d, want %0d", rsp_tdata[27:26], e.ctype));
      if (rsp_tdata[35:28] !== e.cerr)
         report_mismatch($sformatf("card_error_byte %h, want %h", rsp_tdata[35:28], e.cerr));
      if (rsp_tdata[39:36] !== 4'h0)
         report_mismatch($sformatf("pad bits %h", rsp_tdata[39:36]));
   endtask

   // receiver: checks and drives tready, with a counted hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (hold_request) begin
         hold_left = 400;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= stall_pct;
      end
   end

   task automatic send_item(logic [2:0] kind, logic [31:0] addr, logic [7:0] cb,
                            logic [7:0] wb, logic to);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'b0, to, wb, cb, addr};
      do @(posedge clock); while (!req_tready);
      predict_transaction(kind, addr, cb, wb, to);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limits(int unsigned rdy, int unsigned poll, int unsigned tok,
                               int unsigned acmd);
      drain();
      csr_write <= 1'b1; csr_index <= CSR_READY_WAIT; csr_data <= rdy;
      @(posedge clock);
      csr_index <= CSR_POLL; csr_data <= poll;
      @(posedge clock);
      csr_index <= CSR_TOKEN_WAIT; csr_data <= tok;
      @(posedge clock);
      csr_index <= CSR_ACMD_RETRY; csr_data <= acmd;
      @(posedge clock);
      csr_write <= 1'b0;
      lim_ready = rdy; lim_poll = poll; lim_token = tok; lim_acmd = acmd;
   endtask

   function automatic logic [7:0] pick(int pct, logic [7:0] good);
      return $urandom_range(0, 99) < pct ? good : 8'($urandom);
   endfunction

   // what a mostly well-behaved card answers in the current predicted phase
   function automatic logic [7:0] card_answer();
      if (pr_phase == PH_POLL && $urandom_range(0, 99) < 30) return IDLE_BYTE;
      case (pr_phase)
         PH_RDY:   return pick(85, IDLE_BYTE);
         PH_POLL: begin
            case (pr_cmd)
               CMD0:  return pick(90, 8'h01);
               CMD8:  return $urandom_range(0, 99) < 85 ? 8'h01 : 8'h05;
               CMD55: return 8'h01;
               CMD41: return $urandom_range(0, 1) ? 8'h00 : 8'h01;
               CMD13: return pick(85, 8'h00);
               default: return pick(90, 8'h00);
            endcase
         end
         PH_R7:    return pr_index == 3 ? pick(90, CHECK_BYTE) : 8'($urandom);
         PH_OCR:   return pr_index == 0 ? pick(80, 8'hC0 | 8'($urandom_range(0, 63)))
                                        : 8'($urandom);
         PH_TOKEN: return $urandom_range(0, 99) < 30 ? IDLE_BYTE : pick(85, DATA_TOKEN);
         PH_WCRC:  return pr_index == 2 ?
                          pick(85, {3'($urandom), DRESP_OK}) : 8'($urandom);
         PH_WBUSY: return $urandom_range(0, 99) < 30 ? IDLE_BYTE : 8'($urandom);
         PH_STAT2: return pick(85, 8'h00);
         default:  return 8'($urandom);
      endcase
   endfunction

   task automatic send_noise();
      logic [2:0] k;
      k = $urandom_range(0, 7);
      if (k == KIND_CARD || k == KIND_WDATA) k = 3'd5 + 3'($urandom_range(0, 2));
      send_item(k, $urandom, $urandom, $urandom, $urandom_range(0, 1));
   endtask

   // one request carried through to its done result
   task automatic run_operation(logic [2:0] kind, logic to);
      send_item(kind, $urandom, $urandom, $urandom, to);
      while (pr_phase != PH_IDLE) begin
         if ($urandom_range(0, 19) == 0) send_noise();
         else if (pr_phase == PH_WNEED) send_item(KIND_WDATA, $urandom, $urandom, $urandom, 0);
         else send_item(KIND_CARD, $urandom, card_answer(), $urandom, 0);
      end
   endtask

   task automatic test_ignored_items();
      send_item(3'd5, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1);
      send_item(3'd6, 32'h0, 8'h00, 8'h00, 0);
      send_item(3'd7, $urandom, $urandom, $urandom, 1);
      send_item(KIND_CARD, $urandom, 8'hFF, 8'h00, 0);
      send_item(KIND_WDATA, $urandom, 8'h00, 8'hFF, 1);
   endtask

   task automatic test_unknown_card();
      send_item(KIND_READ, 32'hFFFF_FFFF, 8'h00, 8'h00, 0);
      send_item(KIND_WRITE, 32'h0, 8'hFF, 8'hFF, 0);
   endtask

   task automatic test_cmd0_reject();
      send_item(KIND_INIT, 32'h0, 8'h00, 8'h00, 0);
      while (pr_phase != PH_IDLE) begin
         if (pr_phase == PH_POLL) send_item(KIND_CARD, 32'h0, 8'h00, 8'h00, 0);
         else send_item(KIND_CARD, 32'h0, IDLE_BYTE, 8'h00, 0);
      end
   endtask

   task automatic test_random_phase(int idle, int stall, int item_goal);
      int start_count;
      int pick_op;
      send_idle_pct = idle;
      stall_pct = stall;
      start_count = items_sent;
      while (items_sent - start_count < item_goal) begin
         pick_op = $urandom_range(0, 9);
         if (pr_card != CARD_SDHC || pick_op < 2) run_operation(KIND_INIT, 0);
         else if (pick_op < 6) run_operation(KIND_READ, $urandom_range(0, 4) == 0);
         else run_operation(KIND_WRITE, $urandom_range(0, 4) == 0);
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_request = 1;
      run_operation(KIND_INIT, 0);
      if (pr_card == CARD_SDHC) run_operation(KIND_READ, 0);
   endtask

   initial begin
      lim_ready = 65536; lim_poll = 256; lim_token = 8192; lim_acmd = 8192;
      pr_phase = PH_IDLE; pr_op = OP_NONE; pr_card = CARD_UNKNOWN;
      pr_wait = 0; pr_retry = 0; pr_index = 0; pr_cmd = '0; pr_arg = '0;
      pr_block = '0; pr_status = '0; pr_card_err = '0; pr_resp = 8'hFF;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ignored_items();
      test_unknown_card();
      test_cmd0_reject();

      write_limits(65536, 256, 65535, 65535);
      test_random_phase(0, 0, 60);
      write_limits(1, 1, 1, 1);
      test_random_phase(82, 0, 30);
      write_limits($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 4),
                   $urandom_range(1, 3));
      test_random_phase(0, 82, 45);
      write_limits($urandom_range(2, 4), $urandom_range(2, 3), $urandom_range(2, 6),
                   $urandom_range(2, 4));
      test_random_phase(9, 9, 45);
      write_limits(65536, 256, 8192, 8192);
      test_backpressure();

      drain();
      if (error_count == 0)
         $display("sd_card_spi_host_sequencer regression: pass");
      else
         $display("sd_card_spi_host_sequencer regression: fail");
      $finish;
   end

endmodule

// ===== sd_card_spi_host_sequencer.f =====
hw/rtl/sdsh_pkg.sv
hw/rtl/sd_card_spi_host_sequencer.sv
sim/tb_top.sv
